// ===== rtl/keypad_matrix_debouncer_unit_defines.svh =====
`ifndef KEYPAD_MATRIX_DEBOUNCER_UNIT_DEFINES_SVH
`define KEYPAD_MATRIX_DEBOUNCER_UNIT_DEFINES_SVH

// same-cycle implication
`define KMD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmd assertion failed");

// next-cycle implication
`define KMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmd assertion failed");

`endif

// ===== rtl/kmd_pkg.sv =====
package kmd_pkg;

  localparam int COUNT_W    = 8;
  localparam int DEB_W      = 7;
  localparam int POS_W      = 5;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RST   = 7'd3;
  localparam logic [COUNT_W-1:0] HOLD_FIRST_RST = 8'd50;

  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd0;
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
  localparam logic [KIND_W-1:0] EV_HOLD    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_EN    = 2'd2;

  typedef struct packed {
    logic flip;
    logic press;
    logic hold_cand;
  } lane_status_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [KIND_W-1:0] kind;
  } event_t;

endpackage

// ===== rtl/kmd_scan_if.sv =====
interface kmd_scan_if #(
  parameter int W = 25
);
  logic         valid;
  logic         ready;
  logic [W-1:0] matrix_levels;

  modport source (output valid, output matrix_levels, input ready);
  modport sink (input valid, input matrix_levels, output ready);
endinterface

// ===== rtl/kmd_event_if.sv =====
interface kmd_event_if;
  logic       valid;
  logic       ready;
  logic [4:0] key_position;
  logic [1:0] event_kind;
  logic       last_event;

  modport source (output valid, output key_position, output event_kind, output last_event,
                  input ready);
  modport sink (input valid, input key_position, input event_kind, input last_event,
                output ready);
endinterface

// ===== rtl/keypad_matrix_debouncer_unit.sv =====
// Keypad matrix debouncer. Each scan word on the scan channel is a snapshot of the key
// matrix (1 released, 0 pressed). All keys are updated together in parallel lanes,
// then a merge walker visits one key per cycle, unless the event side stalls, and emits
// release, press and hold events in key order; the final event of a scan carries
// last_event. A scan consists of one lane update, a walk over every key and a flush,
// plus any stalls on the event side; the per-key walk makes up most of it. An idle
// all-released scan is accepted with no events and starts no walk. Registers:
// 0 debounce_count, 1 hold_first_count, 2 hold_enable, via cfg_we/cfg_index/cfg_data.
module keypad_matrix_debouncer_unit #(
  parameter int LINES  = 5,
  parameter int SENSES = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  kmd_scan_if.sink                           scan,
  kmd_event_if.source                        evt,
  input  logic                               cfg_we,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import kmd_pkg::*;

  localparam int KEYS = LINES * SENSES;

  logic [DEB_W-1:0]   debounce_count;
  logic [COUNT_W-1:0] hold_first_count;
  logic               hold_enable;
  logic               activity_seen;

  logic               busy;
  logic               pressed_none;
  logic               accept;
  logic               idle_scan;
  logic               start;
  logic [KEYS-1:0]    changed;
  logic [KEYS-1:0]    hold_clear;
  lane_status_t       status [KEYS];
  logic [COUNT_W-1:0] counts [KEYS];

  assign scan.ready = !busy;
  assign accept     = scan.valid && scan.ready;
  assign idle_scan  = pressed_none && !activity_seen && (scan.matrix_levels == '1);
  assign start      = accept && !idle_scan;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count   <= DEBOUNCE_RST;
      hold_first_count <= HOLD_FIRST_RST;
      hold_enable      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_count   <= cfg_data[DEB_W-1:0];
        REG_HOLD_FIRST: hold_first_count <= cfg_data[COUNT_W-1:0];
        REG_HOLD_EN:    hold_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      activity_seen <= 1'b0;
    end else if (start) begin
      activity_seen <= |changed;
    end
  end

  for (genvar i = 0; i < KEYS; i++) begin : g_lane
    kmd_lane u_lane (
      .clk              (clk),
      .rst              (rst),
      .load             (start),
      .lvl              (scan.matrix_levels[i]),
      .hold_clear       (hold_clear[i]),
      .debounce_count   (debounce_count),
      .hold_first_count (hold_first_count),
      .hold_enable      (hold_enable),
      .count            (counts[i]),
      .status           (status[i]),
      .changed          (changed[i])
    );
  end

  kmd_merge #(
    .KEYS (KEYS)
  ) u_merge (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .debounce_count   (debounce_count),
    .hold_first_count (hold_first_count),
    .status           (status),
    .counts           (counts),
    .hold_clear       (hold_clear),
    .busy             (busy),
    .pressed_none     (pressed_none),
    .evt              (evt)
  );

endmodule

// ===== rtl/kmd_lane.sv =====
module kmd_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          lvl,
  input  logic                          hold_clear,
  input  logic [kmd_pkg::DEB_W-1:0]     debounce_count,
  input  logic [kmd_pkg::COUNT_W-1:0]   hold_first_count,
  input  logic                          hold_enable,
  output logic [kmd_pkg::COUNT_W-1:0]   count,
  output kmd_pkg::lane_status_t         status,
  output logic                          changed
);
  import kmd_pkg::*;

  logic               prev;
  logic               stat;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] count_next;
  logic               flip;

  always_comb begin
    sum = {1'b0, count} + (COUNT_W+1)'(1);
    if (sum > {1'b0, hold_first_count}) begin
      count_next = hold_first_count;
    end else begin
      count_next = sum[COUNT_W-1:0];
    end
    changed = (lvl != prev);
    flip = !changed && (count_next >= {1'b0, debounce_count}) && (lvl != stat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev   <= 1'b1;
      stat   <= 1'b1;
      count  <= '0;
      status <= '0;
    end else if (load) begin
      if (changed) begin
        count  <= COUNT_W'(1);
        prev   <= lvl;
        status <= '0;
      end else begin
        count            <= count_next;
        status.flip      <= flip;
        status.press     <= !lvl;
        status.hold_cand <= hold_enable && !lvl && !flip;
        if (flip) begin
          stat <= lvl;
        end
      end
    end else if (hold_clear) begin
      count <= COUNT_W'(1);
    end
  end

endmodule

// ===== rtl/kmd_merge.sv =====
`include "keypad_matrix_debouncer_unit_defines.svh"

module kmd_merge #(
  parameter int KEYS = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [kmd_pkg::DEB_W-1:0]     debounce_count,
  input  logic [kmd_pkg::COUNT_W-1:0]   hold_first_count,
  input  kmd_pkg::lane_status_t         status [KEYS],
  input  logic [kmd_pkg::COUNT_W-1:0]   counts [KEYS],
  output logic [KEYS-1:0]               hold_clear,
  output logic                          busy,
  output logic                          pressed_none,
  kmd_event_if.source                   evt
);
  import kmd_pkg::*;

  localparam int IW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int PW = $clog2(KEYS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t             state;
  logic [IW-1:0]      key_idx;
  logic [PW-1:0]      pressed_total;
  logic [COUNT_W-1:0] hold_threshold;
  logic               pend_valid;
  event_t             pend;
  logic               out_valid;
  event_t             out_word;
  logic               out_last;

  lane_status_t       cur;
  logic [COUNT_W-1:0] cur_cnt;
  logic               is_hold;
  logic               found;
  logic               slot_free;
  logic               advance;
  logic               push;
  logic [IW:0]        pos_full;
  event_t             new_word;

  always_comb begin
    cur       = status[key_idx];
    cur_cnt   = counts[key_idx];
    is_hold   = !cur.flip && cur.hold_cand && (cur_cnt >= hold_threshold);
    found     = cur.flip || is_hold;
    slot_free = !out_valid || evt.ready;
    advance   = (state == ST_WALK) && (!found || !pend_valid || slot_free);
    push      = (advance && found && pend_valid) ||
                ((state == ST_FLUSH) && pend_valid && slot_free);
    pos_full  = {1'b0, key_idx} + (IW+1)'(1);
    new_word.pos = POS_W'(pos_full);
    if (is_hold) begin
      new_word.kind = EV_HOLD;
    end else if (cur.press) begin
      new_word.kind = EV_PRESS;
    end else begin
      new_word.kind = EV_RELEASE;
    end
    hold_clear = '0;
    if (advance && is_hold) begin
      hold_clear[key_idx] = 1'b1;
    end
  end

  assign busy             = (state != ST_IDLE);
  assign pressed_none     = (pressed_total == '0);
  assign evt.valid        = out_valid;
  assign evt.key_position = out_word.pos;
  assign evt.event_kind   = out_word.kind;
  assign evt.last_event   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      key_idx        <= '0;
      pressed_total  <= '0;
      hold_threshold <= HOLD_FIRST_RST;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_valid && evt.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state   <= ST_WALK;
            key_idx <= '0;
          end
        end
        ST_WALK: begin
          if (advance) begin
            if (found) begin
              if (cur.flip) begin
                if (cur.press) begin
                  pressed_total <= pressed_total + PW'(1);
                end else begin
                  pressed_total  <= pressed_total - PW'(1);
                  hold_threshold <= hold_first_count;
                end
              end else begin
                hold_threshold <= {debounce_count, 1'b0};
              end
              if (pend_valid) begin
                out_word  <= pend;
                out_last  <= 1'b0;
              end
              pend       <= new_word;
              pend_valid <= 1'b1;
            end
            if (key_idx == IW'(KEYS - 1)) begin
              state <= ST_FLUSH;
            end else begin
              key_idx <= key_idx + IW'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            out_word   <= pend;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `KMD_ASSERT_NOW(a_idle_no_pending, clk, rst, state == ST_IDLE, !pend_valid)
  `KMD_ASSERT_NEXT(a_stall_holds_key, clk, rst,
                   (state == ST_WALK) && found && pend_valid && !slot_free,
                   $stable(key_idx) && pend_valid)
  `KMD_ASSERT_NOW(a_pressed_bound, clk, rst, 1'b1, pressed_total <= PW'(KEYS))
  `KMD_ASSERT_NOW(a_one_hold_clear, clk, rst, 1'b1, $onehot0(hold_clear))

endmodule

// ===== tb/tb_keypad_matrix_debouncer_unit.sv =====
`timescale 1ns / 1ps

module tb_keypad_matrix_debouncer_unit;
  import kmd_pkg::*;

  localparam int KEYS            = 25;
  localparam int SCAN_CYCLES     = KEYS + 2;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
  localparam logic [KEYS-1:0]      ALL_RELEASED = '1;
  localparam logic [KEYS-1:0]      ALL_PRESSED  = '0;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [KIND_W-1:0] kind;
    logic              last_flag;
  } key_event_t;

  class key_event_tracker;
    logic [DEB_W-1:0]   debounce_cnt;
    logic [COUNT_W-1:0] hold_first;
    logic               hold_on;
    logic [KEYS-1:0]    last_levels;
    logic [KEYS-1:0]    settled_levels;
    logic [COUNT_W-1:0] stable_run [KEYS];
    logic [POS_W-1:0]   held_keys;
    logic               busy_scan;
    logic [COUNT_W-1:0] repeat_thr;
    key_event_t         expected_events [$];
    int                 mismatches;

    function new();
      debounce_cnt   = DEBOUNCE_RST;
      hold_first     = HOLD_FIRST_RST;
      hold_on        = 1'b1;
      last_levels    = ALL_RELEASED;
      settled_levels = ALL_RELEASED;
      foreach (stable_run[k]) stable_run[k] = '0;
      held_keys      = '0;
      busy_scan      = 1'b0;
      repeat_thr     = HOLD_FIRST_RST;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEBOUNCE:   debounce_cnt = data[DEB_W-1:0];
        REG_HOLD_FIRST: hold_first = data;
        REG_HOLD_EN:    hold_on = data[0];
        default: ;
      endcase
    endfunction

    function void take_scan(logic [KEYS-1:0] levels);
      key_event_t        batch [$];
      key_event_t        ev;
      logic              changed;
      logic              fire;
      logic              lvl;
      logic [KIND_W-1:0] kind;
      int                run;
      changed = 1'b0;
      if (held_keys == 0 && !busy_scan && levels == ALL_RELEASED) return;
      for (int k = 0; k < KEYS; k++) begin
        lvl  = levels[k];
        fire = 1'b0;
        kind = EV_RELEASE;
        if (lvl == last_levels[k]) begin
          run = int'(stable_run[k]) + 1;
          if (run > int'(hold_first)) run = int'(hold_first);
          stable_run[k] = COUNT_W'(run);
          if (run >= int'(debounce_cnt) && lvl != settled_levels[k]) begin
            settled_levels[k] = lvl;
            fire = 1'b1;
            if (!lvl) begin
              held_keys++;
              kind = EV_PRESS;
            end else begin
              held_keys--;
              repeat_thr = hold_first;
              kind = EV_RELEASE;
            end
          end else if (hold_on && run >= int'(repeat_thr) && !lvl) begin
            fire = 1'b1;
            kind = EV_HOLD;
            stable_run[k] = 1;
            repeat_thr = {debounce_cnt, 1'b0};
          end
        end else begin
          stable_run[k] = 1;
          changed = 1'b1;
        end
        if (fire) begin
          ev.pos       = POS_W'(k + 1);
          ev.kind      = kind;
          ev.last_flag = 1'b0;
          batch.push_back(ev);
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last_flag = 1'b1;
      foreach (batch[i]) expected_events.push_back(batch[i]);
      if (changed) begin
        last_levels = levels;
        busy_scan = 1'b1;
      end else begin
        busy_scan = 1'b0;
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void report(string what, key_event_t want, key_event_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t %s: expected pos %0d kind %0d last %0d, got pos %0d kind %0d last %0d",
                 $time, what, want.pos, want.kind, want.last_flag,
                 got.pos, got.kind, got.last_flag);
    endfunction

    function void check_key_event(key_event_t got);
      key_event_t want;
      if (expected_events.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      want = expected_events.pop_front();
      if (got.pos !== want.pos || got.kind !== want.kind || got.last_flag !== want.last_flag)
        report("mismatch", want, got);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kmd_scan_if #(.W(KEYS)) scan_bus ();
  kmd_event_if            evt_bus ();

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off_req;
  int hold_off_left;
  int cycle_count;

  key_event_tracker tracker = new();

  keypad_matrix_debouncer_unit #(
    .LINES  (5),
    .SENSES (5)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .scan      (scan_bus),
    .evt       (evt_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && evt_bus.valid && evt_bus.ready)
      tracker.check_key_event({evt_bus.key_position, evt_bus.event_kind, evt_bus.last_event});
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    evt_bus.ready = 1'b0;
    hold_off_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_left = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_off_left > 0) begin
        evt_bus.ready = 1'b0;
        hold_off_left--;
      end else begin
        evt_bus.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_scan(input logic [KEYS-1:0] levels);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      scan_bus.valid = 1'b0;
      @(negedge clk);
    end
    scan_bus.valid = 1'b1;
    scan_bus.matrix_levels = levels;
    while (!scan_bus.ready) @(negedge clk);
    @(posedge clk);
    tracker.take_scan(levels);
  endtask

  task automatic send_repeat(input logic [KEYS-1:0] levels, input int count);
    repeat (count) send_scan(levels);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // drop valid, wait for all events, then let a silent scan finish
  task automatic settle();
    @(negedge clk);
    scan_bus.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SCAN_CYCLES + 8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] hf,
                           input logic [CFG_DATA_W-1:0] en, input int send_pct,
                           input int stall_pct, input int items, input bit pressure);
    logic [KEYS-1:0] snap;
    logic [31:0]     word;
    int              idx;
    int              reps;
    int              max_run;
    int              sent;
    write_cfg(REG_DEBOUNCE, deb);
    write_cfg(REG_HOLD_FIRST, hf);
    write_cfg(REG_HOLD_EN, en);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    if (pressure) hold_off_req = 1'b1;
    max_run = int'(hf) + 2 * int'(deb) + 2;
    if (max_run > 20) max_run = 20;
    snap = ALL_RELEASED;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(1, 3)) begin
            idx = $urandom_range(KEYS - 1);
            snap[idx] = ~snap[idx];
          end
        end
        5: snap = ALL_RELEASED;
        6: snap = ALL_PRESSED;
        7: begin
          word = $urandom;
          snap = word[KEYS-1:0];
        end
        8: begin
          snap = ALL_RELEASED;
          snap[$urandom_range(KEYS - 1)] = 1'b0;
        end
        default: begin
          word = $urandom;
          snap = snap | word[KEYS-1:0];
        end
      endcase
      reps = ($urandom_range(3) == 0) ? 1 : $urandom_range(1, max_run);
      repeat (reps) begin
        if (sent < items) begin
          send_scan(snap);
          sent++;
        end
      end
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data = '0;
    scan_bus.valid = 1'b0;
    scan_bus.matrix_levels = ALL_RELEASED;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    cycle_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: idle scans skipped, all keys pressed then released
    send_repeat(ALL_RELEASED, 2);
    send_repeat(ALL_PRESSED, 3);
    send_repeat(ALL_RELEASED, 3);
    send_scan(25'h1555555);
    send_scan(25'h0AAAAAA);
    settle();

    // zero debounce (masked write), threshold kept until the next release
    write_cfg(REG_DEBOUNCE, 8'h80);
    write_cfg(REG_HOLD_FIRST, 8'd4);
    write_cfg(REG_HOLD_EN, 8'd1);
    write_cfg(REG_UNUSED, 8'hFF);
    send_repeat(25'h1FFFFFE, 4);
    send_repeat(ALL_RELEASED, 2);
    send_repeat(25'h1FFFFFC, 5);
    settle();

    // top key, largest settings, hold off
    write_cfg(REG_HOLD_EN, 8'hFE);
    write_cfg(REG_HOLD_FIRST, 8'hFF);
    write_cfg(REG_DEBOUNCE, 8'hFF);
    send_repeat(25'h0FFFFFF, 3);
    settle();

    // limit lowered below running counters
    write_cfg(REG_HOLD_FIRST, 8'd1);
    write_cfg(REG_DEBOUNCE, 8'd1);
    write_cfg(REG_HOLD_EN, 8'd1);
    send_repeat(25'h0FFFFFF, 2);
    settle();

    run_phase(8'd2, 8'd8, 8'd1, 0, 0, 40, 1'b0);
    run_phase(8'd1, 8'd1, 8'd1, 65, 0, 40, 1'b0);
    run_phase(8'd3, 8'd6, 8'd1, 0, 65, 40, 1'b0);
    run_phase(8'd2, 8'd5, 8'd0, 20, 20, 40, 1'b0);
    run_phase(8'd4, 8'd12, 8'd1, 0, 0, 40, 1'b1);
    run_phase(8'd127, 8'd255, 8'd1, 65, 0, 20, 1'b0);
    run_phase(8'd1, 8'd3, 8'd1, 20, 20, 30, 1'b0);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
